@@ hw/rtl/tcw_pkg.sv @@
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer: grid geometry,
// field widths, item kinds and the structs passed between the modules.
// ---------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // memory address and cursor coordinate widths
    localparam int CELL_AW = $clog2(CELL_COUNT);
    localparam int COL_W   = $clog2(COLUMNS + 1);
    localparam int ROW_W   = $clog2(ROWS);

    // stream field widths
    localparam int KIND_W   = 2;
    localparam int CODE_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int CELL_W   = 16;
    localparam int COLOUR_W = 8;

    localparam int S_TDATA_W = 24;
    localparam int S_PAD_W   = S_TDATA_W - CODE_W - ADDR_W;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - ADDR_W - CELL_W;

    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'd10;

    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'h0a;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h08;

    localparam logic [KIND_W-1:0] KIND_PRINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [ADDR_W-1:0] addr;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor;
        logic [CELL_W-1:0] data;
    } result_t;

endpackage

@@ hw/rtl/tcw_ram.sv @@
// ---------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tcw_seq.sv @@
// ---------------------------------------------------------------------------
// tcw_seq
// Console sequencer: keeps the cursor and drives the cell memory one access
// at a time for writes, reads, backspace row search, scrolling and clearing.
// ---------------------------------------------------------------------------
module tcw_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tcw_pkg::item_t                  in_item,
    input  logic [tcw_pkg::COLOUR_W-1:0]    colour,
    output logic                            res_valid,
    input  logic                            res_ready,
    output tcw_pkg::result_t                res,
    output logic                            ram_we,
    output logic [tcw_pkg::CELL_AW-1:0]     ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]      ram_wdata,
    output logic [tcw_pkg::CELL_AW-1:0]     ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]      ram_rdata
);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DISPATCH = 13'b0000000000100,
        S_WRITE    = 13'b0000000001000,
        S_WRAP     = 13'b0000000010000,
        S_SCAN_RD  = 13'b0000000100000,
        S_SCAN_CHK = 13'b0000001000000,
        S_SCR_RD   = 13'b0000010000000,
        S_SCR_WR   = 13'b0000100000000,
        S_SCR_CLR  = 13'b0001000000000,
        S_READ_RD  = 13'b0010000000000,
        S_READ_CHK = 13'b0100000000000,
        S_RESULT   = 13'b1000000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [tcw_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [tcw_pkg::CODE_W-1:0]      code_reg, code_next;
    logic [tcw_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [tcw_pkg::COL_W-1:0]       col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [tcw_pkg::CELL_AW-1:0]     cnt_reg, cnt_next;
    logic [tcw_pkg::CELL_W-1:0]      data_reg, data_next;
    logic                            adv_reg, adv_next;

    logic [31:0]                     cursor_sum;
    logic [31:0]                     row_base;
    logic [tcw_pkg::CELL_AW-1:0]     cursor_idx;
    logic [tcw_pkg::CELL_W-1:0]      blank;

    assign row_base   = 32'(row_reg) * tcw_pkg::COLUMNS;
    assign cursor_sum = row_base + 32'(col_reg);
    assign cursor_idx = tcw_pkg::CELL_AW'(cursor_sum);
    assign blank      = {colour, {tcw_pkg::CODE_W{1'b0}}};

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESULT);
    assign res.cursor = tcw_pkg::ADDR_W'(cursor_sum);
    assign res.data   = data_reg;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        code_next  = code_reg;
        addr_next  = addr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        data_next  = data_reg;
        adv_next   = adv_reg;
        ram_we     = 1'b0;
        ram_waddr  = cursor_idx;
        ram_wdata  = blank;
        ram_raddr  = cnt_reg;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                if (cnt_reg == tcw_pkg::CELL_AW'(tcw_pkg::CELL_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    kind_next  = in_item.kind;
                    code_next  = in_item.code;
                    addr_next  = in_item.addr;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                data_next = '0;
                adv_next  = 1'b0;
                case (kind_reg)
                    tcw_pkg::KIND_PRINT: begin
                        if (code_reg == tcw_pkg::CODE_NEWLINE) begin
                            // column at the limit makes the wrap step move down a row
                            if (col_reg != '0) begin
                                col_next = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
                            end
                            state_next = S_WRAP;
                        end else if (code_reg == tcw_pkg::CODE_BACKSPACE) begin
                            if (col_reg != '0) begin
                                col_next   = col_reg - 1'b1;
                                state_next = S_WRITE;
                            end else if (row_reg != '0) begin
                                row_next   = row_reg - 1'b1;
                                cnt_next   = '0;
                                state_next = S_SCAN_RD;
                            end else begin
                                state_next = S_WRITE;
                            end
                        end else begin
                            adv_next   = 1'b1;
                            state_next = S_WRITE;
                        end
                    end
                    tcw_pkg::KIND_EOS: begin
                        state_next = S_WRITE;
                    end
                    tcw_pkg::KIND_READ: begin
                        if (32'(addr_reg) < tcw_pkg::CELL_COUNT) begin
                            state_next = S_READ_RD;
                        end else begin
                            state_next = S_RESULT;
                        end
                    end
                    default: begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SCAN_RD: begin
                ram_raddr  = tcw_pkg::CELL_AW'(row_base + 32'(cnt_reg));
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // first empty cell of the row, or the last column
                if (ram_rdata == '0 ||
                    cnt_reg == tcw_pkg::CELL_AW'(tcw_pkg::COLUMNS - 1)) begin
                    col_next   = tcw_pkg::COL_W'(cnt_reg);
                    state_next = S_WRITE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = cursor_idx;
                ram_wdata = adv_reg ? {colour, code_reg} : blank;
                if (adv_reg) begin
                    col_next = col_reg + 1'b1;
                end
                state_next = S_WRAP;
            end
            S_WRAP: begin
                if (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) begin
                    col_next = '0;
                    if (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                        cnt_next   = '0;
                        state_next = S_SCR_RD;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_RESULT;
                    end
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_SCR_RD: begin
                ram_raddr  = tcw_pkg::CELL_AW'(32'(cnt_reg) + tcw_pkg::COLUMNS);
                state_next = S_SCR_WR;
            end
            S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = ram_rdata;
                if (cnt_reg == tcw_pkg::CELL_AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1))
                begin
                    cnt_next   = tcw_pkg::CELL_AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
                    state_next = S_SCR_CLR;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SCR_RD;
                end
            end
            S_SCR_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                if (cnt_reg == tcw_pkg::CELL_AW'(tcw_pkg::CELL_COUNT - 1)) begin
                    state_next = S_RESULT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_READ_RD: begin
                ram_raddr  = tcw_pkg::CELL_AW'(addr_reg);
                state_next = S_READ_CHK;
            end
            S_READ_CHK: begin
                data_next  = ram_rdata;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        code_reg <= code_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        adv_reg  <= adv_next;
    end

endmodule

@@ hw/rtl/text_console_writer.sv @@
// Flow: each item passes the dispatch state, its own steps and the result state, then
// the output register drives m_tvalid. Backspace at column 0 scans the row above cell by cell.
// A scroll copies each cell up a row, one cell per step, then clears the last row.
// Throughput: one item at a time; s_tready rises again in the cycle after the result
// is parked, set by the sequencer making one access at a time to the cell memory.
// Reset: synchronous active-low aresetn; then a grid clear of all CELL_COUNT (2000) cells.
// ---------------------------------------------------------------------------
// text_console_writer
// Text console of COLUMNS x ROWS attribute/character cells with a cursor,
// stream input and output, and an attribute colour register.
// ---------------------------------------------------------------------------
module text_console_writer (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: char_code [7:0], cell_address [18:8], zero pad [23:19]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: kind [1:0]
    input  logic [tcw_pkg::KIND_W-1:0]       s_tuser,
    // m_tdata: cursor_position [10:0], cell_data [26:11], zero pad [31:27]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_wen,
    input  logic [tcw_pkg::COLOUR_W-1:0]     cfg_wdata
);

    logic [tcw_pkg::COLOUR_W-1:0]   colour_reg;
    logic                           m_tvalid_reg;
    tcw_pkg::result_t               m_res_reg;

    tcw_pkg::item_t                 item;
    tcw_pkg::result_t               res;
    logic                           res_valid;
    logic                           res_ready;

    logic                           ram_we;
    logic [tcw_pkg::CELL_AW-1:0]    ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
    logic [tcw_pkg::CELL_AW-1:0]    ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]     ram_rdata;

    assign item.kind = s_tuser;
    assign item.code = s_tdata[tcw_pkg::CODE_W-1:0];
    assign item.addr = s_tdata[tcw_pkg::CODE_W +: tcw_pkg::ADDR_W];

    // output register frees the sequencer once the result is parked
    assign res_ready = !m_tvalid_reg || m_tready;

    tcw_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .colour    (colour_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_reg   <= tcw_pkg::COLOUR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                colour_reg <= cfg_wdata;
            end
            if (res_ready) begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{tcw_pkg::M_PAD_W{1'b0}}, m_res_reg.data, m_res_reg.cursor};

endmodule

@@ hw/rtl/tcw_checker.sv @@
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
module tcw_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata
);

    // grid clearing after reset holds off input
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one item in flight: no transfer the cycle after one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready again right after a transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[tcw_pkg::ADDR_W-1:0]) < tcw_pkg::CELL_COUNT))
        else $error("cursor position outside the grid");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/text_console_writer_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_writer_tb
// Drives console items through the stream input under random gaps and
// back-pressure. A console model in the bench holds the grid, the cursor
// and the colour. A short table of directed items, mostly hand-checked, comes first, then
// randomized text phases under several colour settings. Every result
// transfer is compared field by field with the oldest outstanding
// expectation.
// ---------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int     ITEMS_PER_PHASE = 350;
    localparam int     PHASES          = 4;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     SETTLE_CYCLES   = 64;
    // worst case: every item scrolls, plus both sides' longest waits
    localparam longint CYCLE_LIMIT     = 25_000_000;

    typedef enum int {MIX, LONG_LINE, ERASE} burst_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [ADDR_W-1:0] addr;
        logic              fixed;
        logic [ADDR_W-1:0] cursor;
        logic [CELL_W-1:0] data;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wen   = 1'b0;
    logic [COLOUR_W-1:0]   cfg_wdata = COLOUR_RESET;

    // typed expectation travelling alongside a table row
    logic                  row_fixed  = 1'b0;
    logic [ADDR_W-1:0]     row_cursor = '0;
    logic [CELL_W-1:0]     row_data   = '0;

    // console model state
    logic [CELL_W-1:0]     screen_cells [CELL_COUNT];
    int                    cur_col;
    int                    cur_row;
    logic [COLOUR_W-1:0]   colour_reg;

    result_t               expected_results [$];
    int                    errors       = 0;
    longint                cycle_count  = 0;
    bit                    calm         = 1'b0;
    bit                    hold_request = 1'b0;

    text_console_writer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [CELL_W-1:0] blank_cell();
        return {colour_reg, 8'h00};
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_cells[i] = screen_cells[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_cells[i] = '0;
    endfunction

    function automatic void print_char(logic [CODE_W-1:0] code);
        if (code == CODE_NEWLINE) begin
            if (cur_col != 0) begin
                cur_row++;
                cur_col = 0;
            end
        end else if (code == CODE_BACKSPACE) begin
            if (cur_col != 0) begin
                cur_col--;
            end else if (cur_row != 0) begin
                // previous line: first empty cell, else the last column
                cur_row--;
                cur_col = COLUMNS - 1;
                for (int c = COLUMNS - 1; c >= 0; c--)
                    if (screen_cells[cur_row * COLUMNS + c] == '0)
                        cur_col = c;
            end
            screen_cells[cur_row * COLUMNS + cur_col] = blank_cell();
        end else begin
            screen_cells[cur_row * COLUMNS + cur_col] = {colour_reg, code};
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        while (cur_row >= ROWS) begin
            scroll_screen();
            cur_row--;
        end
    endfunction

    function automatic result_t console_step(logic [KIND_W-1:0] kind,
                                             logic [CODE_W-1:0] code,
                                             logic [ADDR_W-1:0] addr);
        result_t res;
        res.data = '0;
        case (kind)
            KIND_PRINT: begin
                print_char(code);
            end
            KIND_EOS: begin
                screen_cells[cur_row * COLUMNS + cur_col] = blank_cell();
            end
            KIND_READ: begin
                if (addr < CELL_COUNT)
                    res.data = screen_cells[addr];
            end
            default: begin
            end
        endcase
        res.cursor = ADDR_W'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    function automatic stim_row_t make_row(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                           logic [ADDR_W-1:0] addr, logic fixed,
                                           logic [ADDR_W-1:0] cursor, logic [CELL_W-1:0] data);
        stim_row_t row;
        row.kind   = kind;
        row.code   = code;
        row.addr   = addr;
        row.fixed  = fixed;
        row.cursor = cursor;
        row.data   = data;
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                 what, got, want, cycle_count);
        errors++;
    endtask

    // called at a rising edge; returns at the edge of the input transfer
    task automatic send_item(stim_row_t row);
        int gap;
        gap = calm ? 0 : $urandom_range(14, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= row.kind;
        s_tdata    <= {{S_PAD_W{1'b0}}, row.addr, row.code};
        row_fixed  <= row.fixed;
        row_cursor <= row.cursor;
        row_data   <= row.data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_colour(logic [COLOUR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // model update on input transfers, checking on result transfers
    always @(posedge aclk) begin : scoreboard
        result_t got;
        result_t want;
        result_t pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.cursor = m_tdata[ADDR_W-1:0];
                got.data   = m_tdata[ADDR_W +: CELL_W];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", got.cursor, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.cursor !== want.cursor)
                        report_mismatch("cursor_position", got.cursor, want.cursor);
                    if (got.data !== want.data)
                        report_mismatch("cell_data", got.data, want.data);
                end
            end
            if (s_tvalid && s_tready) begin
                pred = console_step(s_tuser, s_tdata[CODE_W-1:0], s_tdata[CODE_W +: ADDR_W]);
                if (row_fixed) begin
                    pred.cursor = row_cursor;
                    pred.data   = row_data;
                end
                expected_results.push_back(pred);
            end
        end
        if (cfg_wen)
            colour_reg = cfg_wdata;
    end

    initial begin : receiver
        int stall;
        @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(14, 0);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        stim_row_t         directed_rows [$];
        stim_row_t         row;
        burst_t            burst_mode;
        int                burst_left;
        int                counted;
        int                sent;
        int                pick;
        logic [COLOUR_W-1:0] phase_colour;

        for (int i = 0; i < CELL_COUNT; i++)
            screen_cells[i] = '0;
        cur_col    = 0;
        cur_row    = 0;
        colour_reg = COLOUR_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-checked rows run with the reset colour
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd0,    1'b1, 11'd0, 16'h0000));
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd1999, 1'b1, 11'd0, 16'h0000));
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd2000, 1'b1, 11'd0, 16'h0000));
        directed_rows.push_back(make_row(KIND_READ,   8'hff, 11'd2047, 1'b1, 11'd0, 16'h0000));
        directed_rows.push_back(make_row(KIND_UNUSED, 8'hff, 11'd2047, 1'b1, 11'd0, 16'h0000));
        // backspace in the top-left corner: cursor stays, cell blanked
        directed_rows.push_back(make_row(KIND_PRINT, CODE_BACKSPACE, 11'd0, 1'b1, 11'd0, 16'h0));
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd0,    1'b1, 11'd0, 16'h0a00));
        // newline at column 0 does not move
        directed_rows.push_back(make_row(KIND_PRINT, CODE_NEWLINE, 11'd0, 1'b1, 11'd0, 16'h0));
        directed_rows.push_back(make_row(KIND_PRINT,  8'h41, 11'd0,    1'b1, 11'd1, 16'h0000));
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd0,    1'b1, 11'd1, 16'h0a41));
        directed_rows.push_back(make_row(KIND_PRINT,  8'h00, 11'd0,    1'b1, 11'd2, 16'h0000));
        directed_rows.push_back(make_row(KIND_PRINT,  8'hff, 11'd0,    1'b1, 11'd3, 16'h0000));
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd2,    1'b1, 11'd3, 16'h0aff));
        directed_rows.push_back(make_row(KIND_PRINT, CODE_BACKSPACE, 11'd0, 1'b1, 11'd2, 16'h0));
        directed_rows.push_back(make_row(KIND_EOS,    8'h00, 11'd0,    1'b1, 11'd2, 16'h0000));
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd2,    1'b1, 11'd2, 16'h0a00));
        directed_rows.push_back(make_row(KIND_PRINT, CODE_NEWLINE, 11'd0, 1'b1, 11'd80, 16'h0));
        // backspace at column 0 lands on the first empty cell of the line above
        directed_rows.push_back(make_row(KIND_PRINT, CODE_BACKSPACE, 11'd0, 1'b1, 11'd3, 16'h0));
        directed_rows.push_back(make_row(KIND_READ,   8'h00, 11'd3,    1'b1, 11'd3, 16'h0a00));
        directed_rows.push_back(make_row(KIND_PRINT,  8'h7f, 11'h7ff,  1'b0, '0, '0));
        directed_rows.push_back(make_row(KIND_PRINT,  8'h80, 11'h000,  1'b0, '0, '0));
        directed_rows.push_back(make_row(KIND_READ,   8'haa, 11'h555,  1'b0, '0, '0));
        directed_rows.push_back(make_row(KIND_EOS,    8'h55, 11'h2aa,  1'b0, '0, '0));
        directed_rows.push_back(make_row(KIND_PRINT, CODE_NEWLINE, 11'd0, 1'b0, '0, '0));

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        sent       = 0;
        burst_left = 0;
        burst_mode = MIX;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       phase_colour = 8'h00;
                1:       phase_colour = 8'hff;
                default: phase_colour = COLOUR_W'($urandom_range(255, 0));
            endcase
            write_colour(phase_colour);
            // stall the result side long enough to back up the input
            if (phase == 1)
                hold_request = 1'b1;
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                if (sent % 40 == 0)
                    calm = ($urandom_range(3, 0) == 0);
                if (burst_left == 0) begin
                    pick = $urandom_range(99, 0);
                    if (pick < 1) begin
                        burst_mode = LONG_LINE;
                        burst_left = $urandom_range(170, 30);
                    end else if (pick < 3) begin
                        burst_mode = ERASE;
                        burst_left = $urandom_range(100, 2);
                    end else begin
                        burst_mode = MIX;
                        burst_left = 1;
                    end
                end
                burst_left--;
                row = make_row(KIND_PRINT, CODE_W'($urandom_range(255, 0)),
                               ADDR_W'($urandom_range(2047, 0)), 1'b0, '0, '0);
                case (burst_mode)
                    LONG_LINE: row.code = CODE_W'($urandom_range(126, 32));
                    ERASE:     row.code = CODE_BACKSPACE;
                    default: begin
                        pick = $urandom_range(99, 0);
                        if (pick < 55) begin
                            row.kind = KIND_PRINT;
                        end else if (pick < 64) begin
                            row.code = CODE_NEWLINE;
                        end else if (pick < 71) begin
                            row.code = CODE_BACKSPACE;
                        end else if (pick < 77) begin
                            row.kind = KIND_EOS;
                        end else if (pick < 95) begin
                            row.kind = KIND_READ;
                            // half the reads aim at the start of lines where text sits
                            if ($urandom_range(1, 0) == 0)
                                row.addr = ADDR_W'($urandom_range(ROWS - 1, 0) * COLUMNS
                                                   + $urandom_range(15, 0));
                        end else begin
                            row.kind = KIND_UNUSED;
                        end
                    end
                endcase
                send_item(row);
                sent++;
                if (row.kind != KIND_UNUSED)
                    counted++;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
